// File: src/assert_macros.svh
// Assertion macros for the design file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/kmd_pkg.sv
package kmd_pkg;

  localparam int unsigned KeyCount = 12;
  localparam int unsigned CountWidth = 8;
  localparam int unsigned CodeWidth = 6;

  localparam logic [CountWidth-1:0] ThresholdReset = 8'd4;

  // Item function codes.
  localparam logic FuncScan = 1'b0;
  localparam logic FuncRead = 1'b1;

  typedef logic [KeyCount-1:0] key_vec_t;

  typedef struct packed {
    logic     func;
    key_vec_t key_sample;
  } kmd_in_t;

  typedef struct packed {
    logic                 event_pending;
    key_vec_t             stable_matrix;
    key_vec_t             changed_mask;
    logic [CodeWidth-1:0] key_code;
    key_vec_t             last_sample;
  } kmd_out_t;

  // Low six bits of the ASCII code of the key when exactly one key is down, else zero.
  // Bit column*4+row; the columns read 1-4-7-*, 2-5-8-0 and 3-6-9-#.
  function automatic logic [CodeWidth-1:0] decode_key(input key_vec_t matrix);
    logic [7:0] code;
    unique case (matrix)
      12'h001: code = 8'h31;
      12'h002: code = 8'h34;
      12'h004: code = 8'h37;
      12'h008: code = 8'h2A;
      12'h010: code = 8'h32;
      12'h020: code = 8'h35;
      12'h040: code = 8'h38;
      12'h080: code = 8'h30;
      12'h100: code = 8'h33;
      12'h200: code = 8'h36;
      12'h400: code = 8'h39;
      12'h800: code = 8'h23;
      default: code = 8'h00;
    endcase
    return code[CodeWidth-1:0];
  endfunction

endpackage

// File: src/kmd_if.sv
interface kmd_in_if;
  import kmd_pkg::*;

  logic    valid;
  logic    ready;
  kmd_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface kmd_out_if;
  import kmd_pkg::*;

  logic     valid;
  logic     ready;
  kmd_out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: src/keypad_matrix_debouncer.sv
// The result of an accepted item transaction is registered and shown on the result channel in the next cycle.
// Throughput: one item per cycle while the result side is ready; the single result register sets the figure and is
// refilled in the same cycle that its result transaction completes.
// Reset (rst, synchronous, active high) clears all key state and the result valid flag,
// and sets the debounce threshold to four.
`include "assert_macros.svh"

module keypad_matrix_debouncer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [kmd_pkg::CountWidth-1:0] cfg_wdata,
  kmd_in_if.sink                       item,
  kmd_out_if.source                    result
);
  import kmd_pkg::*;

  // Debounce state. The threshold is reset to ThresholdReset; every other register here
  // mirrors one piece of the keypad state and is cleared at reset.
  logic [CountWidth-1:0] threshold;
  key_vec_t              previous_sample;
  logic [CountWidth-1:0] debounce_count;
  key_vec_t              changed_keys;
  key_vec_t              stable_keys;
  key_vec_t              raw_sample;

  key_vec_t              previous_sample_next;
  logic [CountWidth-1:0] debounce_count_next;
  key_vec_t              changed_keys_next;
  key_vec_t              stable_keys_next;
  key_vec_t              raw_sample_next;

  // Result register. Its valid flag is control state; the payload needs no reset.
  logic     result_valid;
  kmd_out_t result_data;
  kmd_out_t result_next;

  logic accept;

  // The result register acts as the output stage: a new item is taken whenever
  // the register is empty or its current result is being taken in this cycle.
  assign item.ready   = !result_valid || result.ready;
  assign accept       = item.valid && item.ready;
  assign result.valid = result_valid;
  assign result.data  = result_data;

  // Next state and result of the item on the input channel. A scan updates the
  // debounce state and reports the state after the update. A read reports the
  // current state, decodes the key only when a change is pending, and then
  // acknowledges that change by clearing the changed mask.
  always_comb begin
    previous_sample_next = previous_sample;
    debounce_count_next  = debounce_count;
    changed_keys_next    = changed_keys;
    stable_keys_next     = stable_keys;
    raw_sample_next      = raw_sample;
    result_next          = '0;

    unique case (item.data.func)
      FuncScan: begin
        raw_sample_next = item.data.key_sample;
        if (item.data.key_sample != previous_sample) begin
          // Any difference restarts the debounce interval.
          previous_sample_next = item.data.key_sample;
          debounce_count_next  = '0;
        end else if (debounce_count < threshold) begin
          // The compare stops the counter at the threshold, so it never wraps.
          debounce_count_next = debounce_count + 1'b1;
        end else if (changed_keys == '0) begin
          // The sample is stable and the previous change has been read.
          changed_keys_next = item.data.key_sample ^ stable_keys;
          stable_keys_next  = item.data.key_sample;
        end
        result_next.event_pending = (changed_keys_next != '0);
        result_next.stable_matrix = stable_keys_next;
        result_next.changed_mask  = changed_keys_next;
        result_next.key_code      = '0;
        result_next.last_sample   = raw_sample_next;
      end
      FuncRead: begin
        result_next.event_pending = (changed_keys != '0);
        result_next.stable_matrix = stable_keys;
        result_next.changed_mask  = changed_keys;
        result_next.key_code      = (changed_keys != '0) ? decode_key(stable_keys) : '0;
        result_next.last_sample   = raw_sample;
        changed_keys_next         = '0;
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= ThresholdReset;
      previous_sample <= '0;
      debounce_count  <= '0;
      changed_keys    <= '0;
      stable_keys     <= '0;
      raw_sample      <= '0;
      result_valid    <= 1'b0;
    end else begin
      // The user must write the threshold only while no item is in flight; the block does not enforce it.
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (accept) begin
        previous_sample <= previous_sample_next;
        debounce_count  <= debounce_count_next;
        changed_keys    <= changed_keys_next;
        stable_keys     <= stable_keys_next;
        raw_sample      <= raw_sample_next;
        result_valid    <= 1'b1;
      end else if (result.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_data <= result_next;
    end
  end

  // A pending change is never overwritten by a scan before it has been read.
  `ASSERT_NEXT(a_pending_held, accept && item.data.func == FuncScan && changed_keys != '0, $stable(changed_keys), "pending change overwritten by a scan")
  // A read always acknowledges the pending change.
  `ASSERT_NEXT(a_read_clears, accept && item.data.func == FuncRead, changed_keys == '0, "read did not clear the changed mask")
  // The stable matrix moves only when no change was pending.
  `ASSERT_SAME(a_stable_gated, !$stable(stable_keys), $past(changed_keys) == '0, "stable matrix changed while a change was pending")
  // Every accepted item leaves a result in the result register.
  `ASSERT_NEXT(a_result_loaded, accept, result_valid, "accepted item produced no result")

endmodule

// File: verif/keypad_matrix_debouncer_test.sv
`timescale 1ns / 100ps

module keypad_matrix_debouncer_test;
  import kmd_pkg::*;

  // Generous bound on the whole run, in clock cycles.
  localparam int unsigned CycleLimit = 300000;

  // Keeps its own copy of the debounce state, works out the result that each accepted
  // item transaction should produce and compares the result transactions against it.
  class key_event_scoreboard;
    logic [CountWidth-1:0] threshold;
    logic [CountWidth-1:0] run_length;
    key_vec_t              candidate;
    key_vec_t              changed;
    key_vec_t              stable;
    key_vec_t              last_raw;
    kmd_out_t              awaited_q[$];
    int unsigned           mismatches;

    function new();
      threshold  = ThresholdReset;
      run_length = '0;
      candidate  = '0;
      changed    = '0;
      stable     = '0;
      last_raw   = '0;
      mismatches = 0;
    endfunction

    function void set_threshold(logic [CountWidth-1:0] value);
      threshold = value;
    endfunction

    function bit drained();
      return awaited_q.size() == 0;
    endfunction

    // The keypad is laid out column by column, four rows to a column.
    function logic [CodeWidth-1:0] key_ascii(key_vec_t matrix);
      string layout;
      byte   glyph;
      int    hits;
      int    pos;
      layout = "147*2580369#";
      hits = 0;
      pos = 0;
      for (int i = 0; i < KeyCount; i++) begin
        if (matrix[i]) begin
          hits++;
          pos = i;
        end
      end
      if (hits != 1) return '0;
      glyph = layout[pos];
      return glyph[CodeWidth-1:0];
    endfunction

    function void note_item(kmd_in_t it);
      kmd_out_t want;
      if (it.func == FuncScan) begin
        last_raw = it.key_sample;
        if (it.key_sample != candidate) begin
          candidate  = it.key_sample;
          run_length = '0;
        end else if (run_length < threshold) begin
          run_length = run_length + 1'b1;
        end else if (changed == '0) begin
          changed = it.key_sample ^ stable;
          stable  = it.key_sample;
        end
      end
      want.event_pending = (changed != '0);
      want.stable_matrix = stable;
      want.changed_mask  = changed;
      want.key_code      = (it.func == FuncRead && changed != '0) ? key_ascii(stable) : '0;
      want.last_sample   = last_raw;
      awaited_q.push_back(want);
      // A read acknowledges the event only after it has been reported.
      if (it.func == FuncRead) changed = '0;
    endfunction

    function void check_result(kmd_out_t got);
      kmd_out_t want;
      bit       bad;
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result transaction with nothing awaited: %p", got);
        return;
      end
      want = awaited_q.pop_front();
      bad = (got.event_pending !== want.event_pending)
         || (got.stable_matrix !== want.stable_matrix)
         || (got.changed_mask  !== want.changed_mask)
         || (got.key_code      !== want.key_code)
         || (got.last_sample   !== want.last_sample);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: pending %b/%b stable %h/%h changed %h/%h code %h/%h raw %h/%h",
                   want.event_pending, got.event_pending, want.stable_matrix,
                   got.stable_matrix, want.changed_mask, got.changed_mask, want.key_code,
                   got.key_code, want.last_sample, got.last_sample);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CountWidth-1:0] cfg_wdata;

  kmd_in_if  item_ch();
  kmd_out_if result_ch();

  keypad_matrix_debouncer DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item     (item_ch),
    .result   (result_ch)
  );

  key_event_scoreboard key_events = new();

  // Idling of the two sides, in cycles out of a hundred, and a one-off hold on the
  // result side that is counted down by the process that drives ready.
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  logic [CountWidth-1:0] cur_threshold = ThresholdReset;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Everything is sampled at the rising edge, so the design's own updates at that edge
  // have not yet been applied when the handshake is looked at.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) key_events.check_result(result_ch.data);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("keypad_matrix_debouncer test failed");
      $finish;
    end
  end

  // The result side: ready changes only at the falling edge. A pending hold takes
  // precedence over the random stalling of the current phase.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        result_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // Offers one item transaction and returns at the rising edge at which it is taken.
  // The next call starts at the following falling edge, so valid stays high between
  // back-to-back items and is assigned only once in any time step.
  task automatic send_item(input logic func, input key_vec_t sample);
    kmd_in_t next_item;
    next_item.func = func;
    next_item.key_sample = sample;
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= next_item;
    do @(posedge clk); while (!item_ch.ready);
    key_events.note_item(next_item);
    items_sent++;
  endtask

  task automatic scan(input key_vec_t sample);
    send_item(FuncScan, sample);
  endtask

  // The sample on a read is ignored by the design, so it is filled with noise.
  task automatic read_event();
    send_item(FuncRead, key_vec_t'($urandom_range(0, 4095)));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    item_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (!key_events.drained()) @(posedge clk);
  endtask

  // Every item produces exactly one result, so once nothing is awaited the design is
  // idle and the threshold can be changed safely.
  task automatic write_threshold(input logic [CountWidth-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    key_events.set_threshold(value);
    cur_threshold = value;
  endtask

  // Mostly well-formed key presses: an optional burst of contact bounce, then the same
  // sample mostly held long enough to pass the debounce, then usually a read. The rest
  // is noise, which also piles up unread events so that later changes are held back.
  task automatic run_random(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    key_vec_t    sample;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 80) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) sample = key_vec_t'(1) << $urandom_range(0, KeyCount - 1);
        else if (pick < 13) sample = '0;
        else sample = key_vec_t'($urandom_range(0, 4095));
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) scan(key_vec_t'($urandom_range(0, 4095)));
        end
        repeat (int'(cur_threshold) + 1 + $urandom_range(0, 2)) scan(sample);
        if ($urandom_range(0, 3) != 0) read_event();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 1) read_event();
          else scan(key_vec_t'($urandom_range(0, 4095)));
        end
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, at the reset threshold first: a read with nothing pending, then
    // one key held until it is accepted.
    read_event();
    repeat (6) scan(12'h100);
    read_event();
    stop_sending();

    // With a threshold of zero a sample is accepted on its second equal scan. The last
    // keys on the pad, several keys at once, a change held back by an unread event and
    // a release to no keys at all.
    write_threshold(8'd0);
    repeat (2) scan(12'h800);
    read_event();
    repeat (2) scan(12'h008);
    read_event();
    repeat (2) scan(12'hFFF);
    repeat (2) scan(12'h000);
    read_event();
    scan(12'h000);
    read_event();
    stop_sending();

    // A counter that has run past a newly lowered threshold lets the sample through on
    // the next equal scan.
    write_threshold(8'd20);
    repeat (12) scan(12'h020);
    stop_sending();
    write_threshold(8'd3);
    scan(12'h020);
    read_event();
    stop_sending();

    // The largest threshold: the counter saturates rather than wrapping, and further
    // equal scans change nothing while the event is unread.
    write_threshold(8'd255);
    repeat (260) scan(12'h400);
    read_event();
    stop_sending();

    // Random part, one phase per idling pattern.
    write_threshold(8'd0);
    run_random(95);
    stop_sending();

    write_threshold(8'd1);
    sender_idle_pct = 73;
    run_random(95);
    stop_sending();

    // The result side holds off for a long stretch at the start, so the single result
    // register fills and the item side is stalled.
    write_threshold(8'd2);
    sender_idle_pct = 0;
    receiver_stall_pct = 73;
    hold_cycles = 60;
    run_random(95);
    stop_sending();

    // Half way through, the sender waits for every outstanding result before going on.
    write_threshold(CountWidth'($urandom_range(0, 6)));
    sender_idle_pct = 32;
    receiver_stall_pct = 32;
    run_random(48);
    stop_sending();
    wait_drained();
    run_random(47);
    stop_sending();

    wait_drained();
    repeat (4) @(posedge clk);
    if (key_events.mismatches == 0) begin
      $display("keypad_matrix_debouncer test passed");
    end else begin
      $display("keypad_matrix_debouncer test failed");
    end
    $finish;
  end

endmodule
